// File: hw/rtl/lvr_pkg.sv
// Shared types, constants and helper functions for the linear value ramp.
`default_nettype none

package lvr_pkg;

  // Widths of the held value and of the tick counters.
  localparam int VALUE_BITS = 32;
  localparam int TIME_BITS  = 16;

  // Fixed widths of the port fields.
  localparam int AMT_BITS = 16;
  localparam int TGT_BITS = 32;
  localparam int OUT_BITS = 32;

  // Derived widths for the interpolation unit.
  localparam int MAG_BITS  = VALUE_BITS + 1;
  localparam int PROD_BITS = MAG_BITS + TIME_BITS;
  localparam int CNT_BITS  = $clog2(MAG_BITS + 1);
  localparam int CMP_BITS  = (TIME_BITS > AMT_BITS) ? TIME_BITS : AMT_BITS;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [TIME_BITS-1:0]         time_t;

  // Status of the interpolation unit as seen by the sequencer.
  typedef struct packed {
    logic done;
  } interp_stat_t;

  // Item kinds.
  localparam logic [1:0] KIND_ADVANCE = 2'd0;
  localparam logic [1:0] KIND_SET     = 2'd1;
  localparam logic [1:0] KIND_INTR    = 2'd2;
  localparam logic [1:0] KIND_SKIP    = 2'd3;

  // End event codes.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_INTR = 2'd2;
  localparam logic [1:0] EV_SKIP = 2'd3;

  // Saturates an incoming target to the signed range of the held value.
  function automatic value_t sat_value(input logic signed [TGT_BITS-1:0] t);
    logic signed [63:0] t64;
    logic signed [63:0] vmax;
    logic signed [63:0] vmin;
    t64  = 64'(t);
    vmax = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    vmin = -vmax - 64'sd1;
    if (t64 > vmax) begin
      t64 = vmax;
    end else if (t64 < vmin) begin
      t64 = vmin;
    end
    return t64[VALUE_BITS-1:0];
  endfunction

  // Saturates an incoming duration to the tick counter range.
  function automatic time_t sat_time(input logic [AMT_BITS-1:0] d);
    logic [63:0] d64;
    logic [63:0] tmax;
    d64  = 64'(d);
    tmax = (64'd1 << TIME_BITS) - 64'd1;
    if (d64 > tmax) begin
      d64 = tmax;
    end
    return d64[TIME_BITS-1:0];
  endfunction

  // Sign-extends or truncates the held value to the output field.
  function automatic logic [OUT_BITS-1:0] to_out(input value_t v);
    logic signed [63:0] v64;
    v64 = 64'(v);
    return v64[OUT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/linear_value_ramp_top.sv
// Top level of the linear value ramp: item sequencer, ramp state and result register.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+----------------------------------------------------
//  in      | in_valid/in_ready  | kind, tick_amount, new_target, new_duration, want_notify
//  out     | out_valid/out_ready| current_value, busy_res, end_event, acted
//
// An item that needs no interpolation passes through the execute, evaluate and finish
// states to its result. One that needs it also waits on the interpolation unit, which
// produces one quotient bit per cycle.
// At most one interpolation is done per item.
// Reset is synchronous and returns the ramp to idle with its start and target values at zero.
// A waiting result holds in the output register; the next item is still accepted
// and its result is held back until the register is free.
`default_nettype none

module linear_value_ramp_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [lvr_pkg::AMT_BITS-1:0] tick_amount,
  input  logic signed [lvr_pkg::TGT_BITS-1:0] new_target,
  input  logic [lvr_pkg::AMT_BITS-1:0] new_duration,
  input  logic                        want_notify,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [lvr_pkg::OUT_BITS-1:0] current_value,
  output logic                        busy_res,
  output logic [1:0]                  end_event,
  output logic                        acted
);
  import lvr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_PRE  = 3'd2;
  localparam logic [2:0] S_EVAL = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Captured item.
  logic [1:0]          kind_q;
  logic [AMT_BITS-1:0] amount_q;
  value_t              tgt_q;
  time_t               dur_q;
  logic                want_q;

  // Ramp state.
  value_t start_value, start_value_next;
  value_t target_value, target_value_next;
  time_t  ramp_length, ramp_length_next;
  time_t  ticks_done, ticks_done_next;
  logic   notify_armed, notify_armed_next;

  // Per-item results.
  logic [1:0] ev_q, ev_next;
  logic       act_q, act_next;
  value_t     res_value, res_value_next;

  logic         iv_go;
  interp_stat_t iv_stat;
  value_t       iv_value;
  value_t       cur;
  time_t        remaining;
  logic         out_load;

  lvr_interp u_interp (
    .clk          (clk),
    .rst          (rst),
    .go           (iv_go),
    .start_value  (start_value),
    .target_value (target_value),
    .ticks        (ticks_done),
    .length       (ramp_length),
    .stat         (iv_stat),
    .value        (iv_value)
  );

  assign in_ready  = (state == S_IDLE);
  assign remaining = ramp_length - ticks_done;
  assign cur       = (state == S_PRE) ? iv_value : start_value;
  assign out_load  = (state == S_FIN) && (!out_valid || out_ready);

  // Item sequencing and state update.
  always_comb begin
    state_next        = state;
    start_value_next  = start_value;
    target_value_next = target_value;
    ramp_length_next  = ramp_length;
    ticks_done_next   = ticks_done;
    notify_armed_next = notify_armed;
    ev_next           = ev_q;
    act_next          = act_q;
    res_value_next    = res_value;
    iv_go             = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        ev_next  = EV_NONE;
        act_next = 1'b0;
        if ((kind_q == KIND_SET || kind_q == KIND_INTR) && ramp_length != '0) begin
          // A running ramp must be frozen at its current value first.
          iv_go      = 1'b1;
          state_next = S_PRE;
        end else begin
          unique case (kind_q)
            KIND_ADVANCE: begin
              if (ramp_length != '0 && amount_q != '0) begin
                if (CMP_BITS'(amount_q) >= CMP_BITS'(remaining)) begin
                  start_value_next  = target_value;
                  ramp_length_next  = '0;
                  ticks_done_next   = '0;
                  notify_armed_next = 1'b0;
                  if (notify_armed) ev_next = EV_DONE;
                end else begin
                  ticks_done_next = TIME_BITS'(CMP_BITS'(ticks_done) + CMP_BITS'(amount_q));
                end
              end
            end
            KIND_SET: begin
              // Idle, so the held value is the start value.
              if (dur_q == '0 || cur == tgt_q) begin
                start_value_next  = tgt_q;
                target_value_next = tgt_q;
              end else begin
                target_value_next = tgt_q;
                ramp_length_next  = dur_q;
                ticks_done_next   = '0;
                notify_armed_next = want_q;
                act_next          = 1'b1;
              end
            end
            KIND_INTR: begin
              // Interrupt while idle changes nothing.
            end
            KIND_SKIP: begin
              if (ramp_length != '0) begin
                start_value_next  = target_value;
                ramp_length_next  = '0;
                ticks_done_next   = '0;
                notify_armed_next = 1'b0;
                act_next          = 1'b1;
                if (notify_armed) ev_next = EV_SKIP;
              end
            end
            default: begin
            end
          endcase
          state_next = S_EVAL;
        end
      end
      S_PRE: begin
        if (iv_stat.done) begin
          // Freeze the ramp at the interpolated value.
          start_value_next  = cur;
          target_value_next = cur;
          ramp_length_next  = '0;
          ticks_done_next   = '0;
          notify_armed_next = 1'b0;
          if (notify_armed) ev_next = EV_INTR;
          if (kind_q == KIND_INTR) begin
            act_next = 1'b1;
          end else if (dur_q == '0 || cur == tgt_q) begin
            start_value_next  = tgt_q;
            target_value_next = tgt_q;
          end else begin
            target_value_next = tgt_q;
            ramp_length_next  = dur_q;
            notify_armed_next = want_q;
            act_next          = 1'b1;
          end
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        // Interpolate only when ticks have elapsed on a running ramp.
        if (ramp_length != '0 && ticks_done != '0) begin
          iv_go      = 1'b1;
          state_next = S_POST;
        end else begin
          res_value_next = (ramp_length != '0) ? start_value : target_value;
          state_next     = S_FIN;
        end
      end
      S_POST: begin
        if (iv_stat.done) begin
          res_value_next = iv_value;
          state_next     = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control and ramp state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      start_value  <= '0;
      target_value <= '0;
      ramp_length  <= '0;
      ticks_done   <= '0;
      notify_armed <= 1'b0;
    end else begin
      state        <= state_next;
      start_value  <= start_value_next;
      target_value <= target_value_next;
      ramp_length  <= ramp_length_next;
      ticks_done   <= ticks_done_next;
      notify_armed <= notify_armed_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item capture, working results and the output payload.
  always_ff @(posedge clk) begin
    ev_q      <= ev_next;
    act_q     <= act_next;
    res_value <= res_value_next;
    if (in_valid && in_ready) begin
      kind_q   <= kind;
      amount_q <= tick_amount;
      tgt_q    <= sat_value(new_target);
      dur_q    <= sat_time(new_duration);
      want_q   <= want_notify;
    end
    if (out_load) begin
      current_value <= to_out(res_value);
      busy_res      <= (ramp_length != '0);
      end_event     <= ev_q;
      acted         <= act_q;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lvr_interp.sv
// Shared interpolation unit: one multiply, then a bit-serial restoring divide.
`default_nettype none

module lvr_interp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  lvr_pkg::value_t      start_value,
  input  lvr_pkg::value_t      target_value,
  input  lvr_pkg::time_t       ticks,
  input  lvr_pkg::time_t       length,
  output lvr_pkg::interp_stat_t stat,
  output lvr_pkg::value_t      value
);
  import lvr_pkg::*;

  localparam logic [1:0] I_IDLE = 2'd0;
  localparam logic [1:0] I_MUL  = 2'd1;
  localparam logic [1:0] I_DIV  = 2'd2;
  localparam logic [1:0] I_FIN  = 2'd3;

  logic [1:0]          state;
  logic                done;
  logic                neg;
  logic [MAG_BITS-1:0] mag;
  logic [MAG_BITS-1:0] quo;
  logic [MAG_BITS-1:0] base;
  time_t               e;
  time_t               d;
  time_t               rem;
  logic [CNT_BITS-1:0] cnt;

  logic signed [MAG_BITS-1:0] diff;
  logic [MAG_BITS-1:0]        abs_diff;
  logic [PROD_BITS-1:0]       prod;
  logic [TIME_BITS:0]         part;
  logic [TIME_BITS:0]         trial;
  logic                       take;
  logic [MAG_BITS-1:0]        res;

  // Sign and magnitude of the span between start and target.
  assign diff     = MAG_BITS'(target_value) - MAG_BITS'(start_value);
  assign abs_diff = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);

  // The span scaled by the elapsed ticks.
  assign prod = PROD_BITS'(mag) * PROD_BITS'(e);

  // One restoring divide step: bring down the next dividend bit and try the divisor.
  assign part  = {rem, quo[MAG_BITS-1]};
  assign trial = part - {1'b0, d};
  assign take  = (part >= {1'b0, d});

  // Apply the quotient to the start value in the direction of the target.
  assign res = neg ? (base - quo) : (base + quo);

  // Sequencer for the unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= I_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        I_IDLE: if (go) state <= I_MUL;
        I_MUL:  state <= I_DIV;
        I_DIV:  if (cnt == CNT_BITS'(1)) state <= I_FIN;
        I_FIN: begin
          state <= I_IDLE;
          done  <= 1'b1;
        end
        default: state <= I_IDLE;
      endcase
    end
  end

  // Operand and working registers.
  always_ff @(posedge clk) begin
    unique case (state)
      I_IDLE: begin
        if (go) begin
          neg  <= diff[MAG_BITS-1];
          mag  <= abs_diff;
          base <= MAG_BITS'(start_value);
          e    <= ticks;
          d    <= length;
        end
      end
      I_MUL: begin
        // The elapsed ticks stay below the length, so the quotient fits MAG_BITS.
        rem <= prod[PROD_BITS-1:MAG_BITS];
        quo <= prod[MAG_BITS-1:0];
        cnt <= CNT_BITS'(MAG_BITS);
      end
      I_DIV: begin
        rem <= take ? trial[TIME_BITS-1:0] : part[TIME_BITS-1:0];
        quo <= {quo[MAG_BITS-2:0], take};
        cnt <= cnt - CNT_BITS'(1);
      end
      I_FIN: begin
        value <= res[VALUE_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  assign stat.done = done;

endmodule

`default_nettype wire

// File: hw/rtl/lvr_checker.sv
// Port-level checks for the linear value ramp, bound to the top level.
`default_nettype none

module lvr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [lvr_pkg::OUT_BITS-1:0] current_value,
  input logic                        busy_res,
  input logic [1:0]                  end_event,
  input logic                        acted
);
  import lvr_pkg::*;

  // After reset no result is pending and an item can be taken.
  a_reset: assert property (@(posedge clk) rst |=> (!out_valid && in_ready))
    else $error("result pending or input blocked after reset");

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(current_value)
      && $stable(busy_res) && $stable(end_event) && $stable(acted)))
    else $error("stalled result changed");

  // A completed or skipped ramp leaves the block idle.
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (end_event == EV_DONE || end_event == EV_SKIP)) |-> !busy_res)
    else $error("busy after completion or skip");

  // Completion comes only from an advance, a skip always acts.
  a_end_acted: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((end_event != EV_DONE || !acted) && (end_event != EV_SKIP || acted)))
    else $error("return flag does not match end event");

endmodule

bind linear_value_ramp_top lvr_checker u_lvr_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .current_value (current_value),
  .busy_res      (busy_res),
  .end_event     (end_event),
  .acted         (acted)
);

`default_nettype wire
